// ----- rtl/cll_pkg.sv -----
// ----------------------------------------------------------------------------
// cll_pkg
// Shared widths, command and status codes, and the controller/datapath
// command and status bundles of the cursor linked list engine.
// ----------------------------------------------------------------------------
package cll_pkg;

    localparam int SLOTS_DEF = 1024;

    localparam int CMD_W  = 2;
    localparam int POS_W  = 10;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 10;

    typedef logic [LEN_W-1:0] t_len;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // link read source
    localparam logic [1:0] RS_HEAD = 2'd0;
    localparam logic [1:0] RS_FREE = 2'd1;
    localparam logic [1:0] RS_LINK = 2'd2;

    // link write slot
    localparam logic WS_P   = 1'b0;
    localparam logic WS_CUR = 1'b1;

    // link write data
    localparam logic [1:0] WD_LINK = 2'd0;
    localparam logic [1:0] WD_P    = 2'd1;
    localparam logic [1:0] WD_FREE = 2'd2;

    typedef struct packed {
        logic              load;       // latch the accepted item
        logic              walk_init;  // cursor to header, steps = position - 1
        logic              walk_step;  // cursor follows its link
        logic              rd_en;
        logic [1:0]        rd_sel;
        logic              set_p_free; // slot p is the free head
        logic              set_p_link; // slot p is the cursor's successor
        logic              pop;        // unlink p from free chain, store value
        logic              push;       // p becomes the free head
        logic              wr_en;
        logic              wr_slot;
        logic [1:0]        wr_data;
        logic              cnt_inc;
        logic              cnt_dec;
        logic              val_rd;     // fetch value of the cursor's successor
        logic              out_load;
        logic [STAT_W-1:0] out_status;
        logic              out_use_val;
    } t_dp_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             pos_ok;
        logic             free_empty;
        logic             walk_done;
        logic             out_free;
    } t_dp_stat;

endpackage

// ----- rtl/cll_in_if.sv -----
// ----------------------------------------------------------------------------
// cll_in_if
// Command channel: valid/ready with command, position and value.
// ----------------------------------------------------------------------------
interface cll_in_if;
    logic                                valid;
    logic                                ready;
    logic [cll_pkg::CMD_W-1:0]           cmd;
    logic [cll_pkg::POS_W-1:0]           position;
    logic signed [cll_pkg::VAL_W-1:0]    value_in;

    modport source (output valid, output cmd, output position, output value_in,
                    input ready);
    modport sink   (input valid, input cmd, input position, input value_in,
                    output ready);
endinterface

// ----- rtl/cll_out_if.sv -----
// ----------------------------------------------------------------------------
// cll_out_if
// Result channel: valid/ready with status, read value and list length.
// ----------------------------------------------------------------------------
interface cll_out_if;
    logic                                valid;
    logic                                ready;
    logic [cll_pkg::STAT_W-1:0]          status;
    logic signed [cll_pkg::VAL_W-1:0]    value_out;
    logic [cll_pkg::LEN_W-1:0]           list_length;

    modport source (output valid, output status, output value_out,
                    output list_length, input ready);
    modport sink   (input valid, input status, input value_out,
                    input list_length, output ready);
endinterface

// ----- rtl/cll_ctrl.sv -----
// ----------------------------------------------------------------------------
// cll_ctrl
// Command sequencer: range check, free slot pop, link walk, relink and
// result hand-off to the output register.
// ----------------------------------------------------------------------------
module cll_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  cll_pkg::t_dp_stat i_stat,
    output cll_pkg::t_dp_cmd  o_ctl
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_POP   = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;
    localparam logic [2:0] S_INS2  = 3'd4;
    localparam logic [2:0] S_DEL1  = 3'd5;
    localparam logic [2:0] S_DEL2  = 3'd6;
    localparam logic [2:0] S_RESP  = 3'd7;

    logic [2:0]                  r_state, n_state;
    logic [cll_pkg::STAT_W-1:0]  r_status, n_status;
    logic                        r_use_val, n_use_val;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_status  = r_status;
        n_use_val = r_use_val;
        o_ctl     = '0;
        o_ctl.out_status  = r_status;
        o_ctl.out_use_val = r_use_val;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                o_ctl.walk_init = 1'b1;
                n_use_val       = 1'b0;
                n_status        = cll_pkg::ST_OK;
                priority if (i_stat.cmd == cll_pkg::CMD_UNUSED || !i_stat.pos_ok) begin
                    n_status = cll_pkg::ST_RANGE;
                    n_state  = S_RESP;
                end else if (i_stat.cmd == cll_pkg::CMD_INSERT && i_stat.free_empty) begin
                    n_status = cll_pkg::ST_FULL;
                    n_state  = S_RESP;
                end else if (i_stat.cmd == cll_pkg::CMD_INSERT) begin
                    o_ctl.set_p_free = 1'b1;
                    o_ctl.rd_en      = 1'b1;
                    o_ctl.rd_sel     = cll_pkg::RS_FREE;
                    n_state          = S_POP;
                end else begin
                    o_ctl.rd_en  = 1'b1;
                    o_ctl.rd_sel = cll_pkg::RS_HEAD;
                    n_state      = S_WALK;
                end
            end
            S_POP: begin
                o_ctl.pop    = 1'b1;
                o_ctl.rd_en  = 1'b1;
                o_ctl.rd_sel = cll_pkg::RS_HEAD;
                n_state      = S_WALK;
            end
            S_WALK: begin
                if (!i_stat.walk_done) begin
                    o_ctl.walk_step = 1'b1;
                    o_ctl.rd_en     = 1'b1;
                    o_ctl.rd_sel    = cll_pkg::RS_LINK;
                end else begin
                    unique case (i_stat.cmd)
                        cll_pkg::CMD_INSERT: begin
                            // new slot takes over the cursor's successor
                            o_ctl.wr_en   = 1'b1;
                            o_ctl.wr_slot = cll_pkg::WS_P;
                            o_ctl.wr_data = cll_pkg::WD_LINK;
                            n_state       = S_INS2;
                        end
                        cll_pkg::CMD_DELETE: begin
                            o_ctl.set_p_link = 1'b1;
                            o_ctl.rd_en      = 1'b1;
                            o_ctl.rd_sel     = cll_pkg::RS_LINK;
                            n_state          = S_DEL1;
                        end
                        cll_pkg::CMD_READ: begin
                            o_ctl.val_rd = 1'b1;
                            n_use_val    = 1'b1;
                            n_state      = S_RESP;
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_INS2: begin
                o_ctl.wr_en   = 1'b1;
                o_ctl.wr_slot = cll_pkg::WS_CUR;
                o_ctl.wr_data = cll_pkg::WD_P;
                o_ctl.cnt_inc = 1'b1;
                n_state       = S_RESP;
            end
            S_DEL1: begin
                // predecessor skips the removed slot
                o_ctl.wr_en   = 1'b1;
                o_ctl.wr_slot = cll_pkg::WS_CUR;
                o_ctl.wr_data = cll_pkg::WD_LINK;
                n_state       = S_DEL2;
            end
            S_DEL2: begin
                o_ctl.wr_en   = 1'b1;
                o_ctl.wr_slot = cll_pkg::WS_P;
                o_ctl.wr_data = cll_pkg::WD_FREE;
                o_ctl.push    = 1'b1;
                o_ctl.cnt_dec = 1'b1;
                n_state       = S_RESP;
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_ctl.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_use_val <= n_use_val;
    end

`ifndef NO_ASSERTIONS
    a_load_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load |-> (r_state == S_IDLE && i_valid))
        else $error("item latched outside idle");
    a_out_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.out_load |-> i_stat.out_free)
        else $error("result loaded over a pending one");
    a_check_follows_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load |=> (r_state == S_CHECK))
        else $error("accepted item not checked");
`endif

endmodule

// ----- rtl/cll_dpath.sv -----
// ----------------------------------------------------------------------------
// cll_dpath
// Link and value memories, free chain head, header link, walk cursor,
// entry count and the result register.
// ----------------------------------------------------------------------------
module cll_dpath #(
    parameter int SLOTS = cll_pkg::SLOTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [cll_pkg::CMD_W-1:0]         i_cmd,
    input  logic [cll_pkg::POS_W-1:0]         i_pos,
    input  logic signed [cll_pkg::VAL_W-1:0]  i_val,
    input  cll_pkg::t_dp_cmd                  i_ctl,
    output cll_pkg::t_dp_stat                 o_stat,
    cll_out_if.source                         o_res
);

    localparam int SW = $clog2(SLOTS);
    localparam int CMPW = ((SW > cll_pkg::POS_W) ? SW : cll_pkg::POS_W) + 1;
    localparam logic [SW-1:0] HEAD      = SW'(SLOTS - 1);
    localparam logic [SW-1:0] LAST_FREE = SW'(SLOTS - 2);

    logic [SW-1:0]            link_mem  [SLOTS];
    logic [cll_pkg::VAL_W-1:0] value_mem [SLOTS];

    logic [cll_pkg::CMD_W-1:0] r_cmd;
    logic [cll_pkg::POS_W-1:0] r_pos;
    logic [cll_pkg::VAL_W-1:0] r_val;
    logic [SW-1:0]             r_p;
    logic [SW-1:0]             r_cur;
    logic [cll_pkg::POS_W-1:0] r_left;
    logic [SW-1:0]             r_free_head;
    logic [SW-1:0]             r_head_link;
    logic [SW-1:0]             r_fill;   // slots at or above never written
    logic [SW-1:0]             r_count;
    logic [SW-1:0]             r_rd_slot;
    logic                      r_rd_head;
    logic                      r_rd_fresh;
    logic [SW-1:0]             r_link_q;
    logic [cll_pkg::VAL_W-1:0] r_val_q;
    logic                      r_out_valid;
    logic [cll_pkg::STAT_W-1:0] r_out_status;
    logic [cll_pkg::VAL_W-1:0] r_out_value;
    logic [cll_pkg::LEN_W-1:0] r_out_len;

    logic [SW-1:0]   link_val;
    logic [SW-1:0]   fresh_link;
    logic [SW-1:0]   rd_addr;
    logic [SW-1:0]   wr_slot;
    logic [SW-1:0]   wr_data;
    logic            lk_we;
    logic [CMPW-1:0] pos_limit;

    // untouched slots still hold the initial free chain
    assign fresh_link = (r_rd_slot == LAST_FREE) ? '0 : r_rd_slot + 1'b1;
    assign link_val   = r_rd_head ? r_head_link : (r_rd_fresh ? fresh_link : r_link_q);

    always_comb begin
        unique case (i_ctl.rd_sel)
            cll_pkg::RS_HEAD: rd_addr = HEAD;
            cll_pkg::RS_FREE: rd_addr = r_free_head;
            cll_pkg::RS_LINK: rd_addr = link_val;
            default:          rd_addr = HEAD;
        endcase
    end

    assign wr_slot = (i_ctl.wr_slot == cll_pkg::WS_CUR) ? r_cur : r_p;

    always_comb begin
        unique case (i_ctl.wr_data)
            cll_pkg::WD_LINK: wr_data = link_val;
            cll_pkg::WD_P:    wr_data = r_p;
            cll_pkg::WD_FREE: wr_data = r_free_head;
            default:          wr_data = link_val;
        endcase
    end

    // header link lives in a register
    assign lk_we = i_ctl.wr_en && (wr_slot != HEAD);

    assign pos_limit = CMPW'(r_count) + CMPW'(r_cmd == cll_pkg::CMD_INSERT);

    assign o_stat.cmd        = r_cmd;
    assign o_stat.pos_ok     = (r_pos != '0) && (CMPW'(r_pos) <= pos_limit);
    assign o_stat.free_empty = (r_free_head == '0);
    assign o_stat.walk_done  = (r_left == '0);
    assign o_stat.out_free   = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_link_q <= link_mem[rd_addr];
        end
        if (lk_we) begin
            link_mem[wr_slot] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.pop) begin
            value_mem[r_p] <= r_val;
        end
        if (i_ctl.val_rd) begin
            r_val_q <= value_mem[link_val];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head <= SW'(1);
            r_head_link <= '0;
            r_fill      <= SW'(1);
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.pop) begin
                r_free_head <= link_val;
                if (r_rd_fresh) begin
                    r_fill <= r_p + 1'b1;
                end
            end else if (i_ctl.push) begin
                r_free_head <= r_p;
            end
            if (i_ctl.wr_en && (wr_slot == HEAD)) begin
                r_head_link <= wr_data;
            end
            if (i_ctl.cnt_inc) begin
                r_count <= r_count + 1'b1;
            end else if (i_ctl.cnt_dec) begin
                r_count <= r_count - 1'b1;
            end
            if (i_ctl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= i_cmd;
            r_pos <= i_pos;
            r_val <= i_val;
        end
        if (i_ctl.walk_init) begin
            r_cur  <= HEAD;
            r_left <= r_pos - 1'b1;
        end else if (i_ctl.walk_step) begin
            r_cur  <= link_val;
            r_left <= r_left - 1'b1;
        end
        if (i_ctl.set_p_free) begin
            r_p <= r_free_head;
        end else if (i_ctl.set_p_link) begin
            r_p <= link_val;
        end
        if (i_ctl.rd_en) begin
            r_rd_slot  <= rd_addr;
            r_rd_head  <= (rd_addr == HEAD);
            r_rd_fresh <= (rd_addr >= r_fill);
        end
        if (i_ctl.out_load) begin
            r_out_status <= i_ctl.out_status;
            r_out_value  <= i_ctl.out_use_val ? r_val_q : '0;
            r_out_len    <= cll_pkg::t_len'(r_count);
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_out_status;
    assign o_res.value_out   = r_out_value;
    assign o_res.list_length = r_out_len;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LAST_FREE)
        else $error("entry count above capacity");
    a_free_not_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free_head != HEAD) && (r_head_link != HEAD))
        else $error("header slot linked into a chain");
    a_link_write_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lk_we |-> (wr_slot != '0 && wr_slot < r_fill))
        else $error("link written to a slot outside the used range");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.pop |-> (r_p != '0 && r_p != HEAD))
        else $error("pop from an empty free chain");
`endif

endmodule

// ----- rtl/cursor_linked_list_engine.sv -----
// ----------------------------------------------------------------------------
// cursor_linked_list_engine
// Array-backed singly linked list with a free chain: insert, delete and read
// at a 1-based position, one result per command.
// ----------------------------------------------------------------------------
//  port     dir  handshake      payload
//  i_cmd    in   valid/ready    cmd, position, value_in
//  o_res    out  valid/ready    status, value_out, list_length
//
//  one command at a time; the walk follows one link per cycle through the link
//  memory read port
//  reset is synchronous; a fill mark on untouched slots stands in for a clearing pass
//  the next command is accepted while a result waits in the output register;
//  a finished command stalls until that register is free
// ----------------------------------------------------------------------------
module cursor_linked_list_engine #(
    parameter int SLOTS = cll_pkg::SLOTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cll_in_if.sink     i_cmd,
    cll_out_if.source  o_res
);

    cll_pkg::t_dp_cmd  ctl;
    cll_pkg::t_dp_stat stat;

    cll_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cmd.valid),
        .o_ready (i_cmd.ready),
        .i_stat  (stat),
        .o_ctl   (ctl)
    );

    cll_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd.cmd),
        .i_pos   (i_cmd.position),
        .i_val   (i_cmd.value_in),
        .i_ctl   (ctl),
        .o_stat  (stat),
        .o_res   (o_res)
    );

endmodule

// ----- tb/tb_cursor_linked_list_engine.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cursor_linked_list_engine
// Drives insert, delete and read commands into the linked list engine and
// checks every result against a shadow list kept in the bench. The run covers
// edge and out-of-range cases, random traffic on a short list, a fill to a
// long list with deep walks at its end, and a drain back down.
// ----------------------------------------------------------------------------
module tb_cursor_linked_list_engine;

    localparam int SLOTS     = cll_pkg::SLOTS_DEF;
    localparam int HEAD_SLOT = SLOTS - 1;
    localparam int MAX_LEN   = SLOTS - 2;
    localparam int MAX_POS   = (1 << cll_pkg::POS_W) - 1;
    localparam int FILL_LEN  = 160;

    typedef struct packed {
        logic [cll_pkg::CMD_W-1:0]        cmd;
        logic [cll_pkg::POS_W-1:0]        position;
        logic signed [cll_pkg::VAL_W-1:0] value;
    } t_list_cmd;

    typedef struct packed {
        logic [cll_pkg::STAT_W-1:0]       status;
        logic signed [cll_pkg::VAL_W-1:0] value;
        logic [cll_pkg::LEN_W-1:0]        length;
    } t_list_res;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    cll_in_if  cmd_ch ();
    cll_out_if res_ch ();

    cursor_linked_list_engine u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // bench-side drivers, known from time zero
    logic      drv_valid   = 1'b0;
    t_list_cmd drv_payload = '0;
    logic      mon_ready   = 1'b0;

    assign cmd_ch.valid    = drv_valid;
    assign cmd_ch.cmd      = drv_payload.cmd;
    assign cmd_ch.position = drv_payload.position;
    assign cmd_ch.value_in = drv_payload.value;
    assign res_ch.ready    = mon_ready;

    // shadow list
    logic [cll_pkg::VAL_W-1:0] value_mem [SLOTS];
    logic [cll_pkg::POS_W-1:0] link_mem  [SLOTS];
    int unsigned               entry_cnt;

    t_list_cmd   pending_cmds [$];
    t_list_res   expected_results [$];
    int unsigned gen_len;
    int unsigned mismatch_cnt = 0;

    t_list_cmd   drv_item = '0;
    logic        drv_busy = 1'b0;
    logic        drv_calm = 1'b0;
    int unsigned drv_idle = 0;
    logic        mon_calm = 1'b0;
    int unsigned mon_stall = 0;

    function automatic void reset_list_model();
        for (int k = 0; k < SLOTS; k++) begin
            value_mem[k] = '0;
            link_mem[k]  = cll_pkg::POS_W'(k + 1);
        end
        link_mem[SLOTS-2] = '0;
        link_mem[SLOTS-1] = '0;
        entry_cnt = 0;
    endfunction

    // slot whose link points at list position pos
    function automatic logic [cll_pkg::POS_W-1:0] slot_before(int unsigned pos);
        logic [cll_pkg::POS_W-1:0] s;
        s = cll_pkg::POS_W'(HEAD_SLOT);
        for (int unsigned j = 1; j < pos; j++)
            s = link_mem[s];
        return s;
    endfunction

    function automatic t_list_res apply_list_command(t_list_cmd c);
        t_list_res                 r;
        logic [cll_pkg::POS_W-1:0] p;
        logic [cll_pkg::POS_W-1:0] k;
        int unsigned               pos;
        pos      = 32'(c.position);
        r.status = cll_pkg::ST_OK;
        r.value  = '0;
        case (c.cmd)
            cll_pkg::CMD_INSERT: begin
                // range is checked before the free chain
                if (pos == 0 || pos > entry_cnt + 1) begin
                    r.status = cll_pkg::ST_RANGE;
                end else if (link_mem[0] == '0) begin
                    r.status = cll_pkg::ST_FULL;
                end else begin
                    p            = link_mem[0];
                    link_mem[0]  = link_mem[p];
                    value_mem[p] = c.value;
                    k            = slot_before(pos);
                    link_mem[p]  = link_mem[k];
                    link_mem[k]  = p;
                    entry_cnt++;
                end
            end
            cll_pkg::CMD_DELETE: begin
                if (pos == 0 || pos > entry_cnt) begin
                    r.status = cll_pkg::ST_RANGE;
                end else begin
                    k           = slot_before(pos);
                    p           = link_mem[k];
                    link_mem[k] = link_mem[p];
                    link_mem[p] = link_mem[0];
                    link_mem[0] = p;
                    entry_cnt--;
                end
            end
            cll_pkg::CMD_READ: begin
                if (pos == 0 || pos > entry_cnt)
                    r.status = cll_pkg::ST_RANGE;
                else
                    r.value = value_mem[link_mem[slot_before(pos)]];
            end
            default: r.status = cll_pkg::ST_RANGE;
        endcase
        r.length = cll_pkg::LEN_W'(entry_cnt);
        return r;
    endfunction

    function automatic int unsigned draw_idle(logic calm);
        return calm ? 0 : $urandom_range(0, 17);
    endfunction

    function automatic logic [cll_pkg::VAL_W-1:0] draw_value();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return '0;
            3:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // gen_len follows the list length as the commands are queued
    task automatic queue_command(logic [cll_pkg::CMD_W-1:0] cmd, int unsigned pos,
                                 logic [cll_pkg::VAL_W-1:0] val);
        t_list_cmd c;
        c.cmd      = cmd;
        c.position = cll_pkg::POS_W'(pos);
        c.value    = val;
        pending_cmds.push_back(c);
        if (cmd == cll_pkg::CMD_INSERT && pos >= 1 && pos <= gen_len + 1 &&
            gen_len < MAX_LEN)
            gen_len++;
        else if (cmd == cll_pkg::CMD_DELETE && pos >= 1 && pos <= gen_len)
            gen_len--;
    endtask

    task automatic queue_random_command(int unsigned cap);
        int unsigned               roll;
        int unsigned               pos;
        int unsigned               lim;
        logic [cll_pkg::CMD_W-1:0] cmd;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            // noise: any code, any position
            cmd = cll_pkg::CMD_W'($urandom_range(0, 3));
            pos = $urandom_range(0, MAX_POS);
        end else begin
            if (gen_len == 0) begin
                cmd = cll_pkg::CMD_INSERT;
            end else if (gen_len >= cap) begin
                cmd = $urandom_range(0, 1) ? cll_pkg::CMD_DELETE : cll_pkg::CMD_READ;
            end else begin
                roll = $urandom_range(0, 99);
                cmd  = (roll < 45) ? cll_pkg::CMD_INSERT :
                       (roll < 75) ? cll_pkg::CMD_DELETE : cll_pkg::CMD_READ;
            end
            lim  = (cmd == cll_pkg::CMD_INSERT) ? gen_len + 1 : gen_len;
            roll = $urandom_range(0, 9);
            case (roll)
                0:       pos = 1;
                1:       pos = lim;
                2:       pos = lim + 1;
                default: pos = $urandom_range(1, lim);
            endcase
            if (pos > MAX_POS)
                pos = MAX_POS;
        end
        queue_command(cmd, pos, draw_value());
    endtask

    task automatic wait_until_drained();
        while (pending_cmds.size() != 0 || drv_busy || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic note_mismatch(string what, t_list_res want, t_list_res got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
            $write("mismatch (%s): expected status %0d value %0d length %0d,",
                   what, want.status, want.value, want.length);
            $display(" got status %0d value %0d length %0d",
                     got.status, got.value, got.length);
        end
    endtask

    // command driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drv_busy = 1'b0;
            drv_idle = draw_idle(1'b0);
            drv_valid <= 1'b0;
        end else begin
            if (drv_valid && cmd_ch.ready) begin
                expected_results.push_back(apply_list_command(drv_item));
                drv_busy = 1'b0;
                if ($urandom_range(0, 31) == 0)
                    drv_calm = !drv_calm;
                drv_idle = draw_idle(drv_calm);
            end
            if (!drv_busy) begin
                if (drv_idle > 0) begin
                    drv_idle--;
                end else if (pending_cmds.size() > 0) begin
                    drv_item = pending_cmds.pop_front();
                    drv_busy = 1'b1;
                end
            end
            drv_valid   <= drv_busy;
            drv_payload <= drv_item;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_list_res got;
        t_list_res want;
        if (!i_rst_n) begin
            mon_stall = draw_idle(1'b0);
            mon_ready <= 1'b0;
        end else begin
            if (res_ch.valid && mon_ready) begin
                got.status = res_ch.status;
                got.value  = res_ch.value_out;
                got.length = res_ch.list_length;
                if (expected_results.size() == 0) begin
                    note_mismatch("no result expected", '0, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got.status != want.status)
                        note_mismatch("status", want, got);
                    else if (got.value != want.value)
                        note_mismatch("value_out", want, got);
                    else if (got.length != want.length)
                        note_mismatch("list_length", want, got);
                end
                if ($urandom_range(0, 31) == 0)
                    mon_calm = !mon_calm;
                mon_stall = draw_idle(mon_calm);
            end
            if (mon_stall > 0) begin
                mon_stall--;
                mon_ready <= 1'b0;
            end else begin
                mon_ready <= 1'b1;
            end
        end
    end

    initial begin
        int unsigned pos;
        int unsigned lim;
        int unsigned deep;
        reset_list_model();
        gen_len = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty list and bad positions
        queue_command(cll_pkg::CMD_READ, 1, draw_value());
        queue_command(cll_pkg::CMD_DELETE, 1, draw_value());
        queue_command(cll_pkg::CMD_INSERT, 0, draw_value());
        queue_command(cll_pkg::CMD_INSERT, 2, draw_value());
        queue_command(cll_pkg::CMD_UNUSED, 1, draw_value());
        // front, end and middle inserts with extreme values
        queue_command(cll_pkg::CMD_INSERT, 1, 32'h7fff_ffff);
        queue_command(cll_pkg::CMD_INSERT, 1, 32'h8000_0000);
        queue_command(cll_pkg::CMD_INSERT, 3, 32'hffff_ffff);
        queue_command(cll_pkg::CMD_INSERT, 2, 32'h0000_0000);
        for (int unsigned i = 1; i <= 4; i++)
            queue_command(cll_pkg::CMD_READ, i, draw_value());
        queue_command(cll_pkg::CMD_READ, 5, draw_value());
        queue_command(cll_pkg::CMD_READ, 0, draw_value());
        queue_command(cll_pkg::CMD_READ, MAX_POS, draw_value());
        queue_command(cll_pkg::CMD_DELETE, 4, draw_value());
        queue_command(cll_pkg::CMD_DELETE, 1, draw_value());
        queue_command(cll_pkg::CMD_DELETE, 2, draw_value());
        queue_command(cll_pkg::CMD_READ, 1, draw_value());
        queue_command(cll_pkg::CMD_INSERT, MAX_POS, draw_value());
        queue_command(cll_pkg::CMD_UNUSED, 0, draw_value());
        queue_command(cll_pkg::CMD_DELETE, 1, draw_value());
        queue_command(cll_pkg::CMD_DELETE, 1, draw_value());

        for (int i = 0; i < 200; i++)
            queue_random_command(48);
        // hold the sender until the engine has answered everything
        wait_until_drained();

        // grow a long list, mostly near the front to keep walks short
        while (gen_len < FILL_LEN) begin
            lim = (gen_len + 1 < 8) ? gen_len + 1 : 8;
            if ($urandom_range(0, 15) == 0 && gen_len > 0) begin
                queue_command(cll_pkg::CMD_READ,
                              $urandom_range(1, lim < gen_len ? lim : gen_len),
                              draw_value());
            end else begin
                pos = ($urandom_range(0, 63) == 0) ? gen_len + 1 : $urandom_range(1, lim);
                queue_command(cll_pkg::CMD_INSERT, pos, draw_value());
            end
        end

        // deep walks and range edges at the end of the long list
        deep = gen_len;
        queue_command(cll_pkg::CMD_INSERT, deep + 2, draw_value());
        queue_command(cll_pkg::CMD_INSERT, 0, draw_value());
        queue_command(cll_pkg::CMD_READ, deep, draw_value());
        queue_command(cll_pkg::CMD_READ, deep + 1, draw_value());
        queue_command(cll_pkg::CMD_READ, deep / 2, draw_value());
        queue_command(cll_pkg::CMD_DELETE, deep + 1, draw_value());
        queue_command(cll_pkg::CMD_DELETE, deep, draw_value());
        queue_command(cll_pkg::CMD_READ, deep, draw_value());
        queue_command(cll_pkg::CMD_INSERT, deep, draw_value());
        queue_command(cll_pkg::CMD_INSERT, 1, draw_value());
        queue_command(cll_pkg::CMD_DELETE, 1, draw_value());
        queue_command(cll_pkg::CMD_UNUSED, MAX_POS, draw_value());
        wait_until_drained();

        // drain back to a short list, scrambling the free chain
        while (gen_len > 40) begin
            if ($urandom_range(0, 7) == 0)
                queue_command(cll_pkg::CMD_READ, $urandom_range(1, 6), draw_value());
            else
                queue_command(cll_pkg::CMD_DELETE, $urandom_range(1, 6), draw_value());
        end

        for (int i = 0; i < 80; i++)
            queue_random_command(80);

        wait_until_drained();
        repeat (SLOTS + 10) @(posedge i_clk);
        if (mismatch_cnt == 0 && expected_results.size() == 0)
            $display("PASS cursor_linked_list_engine");
        else
            $display("FAIL cursor_linked_list_engine");
        $finish;
    end

    initial begin
        #30_000_000;
        $display("FAIL cursor_linked_list_engine");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/cll_pkg.sv
rtl/cll_in_if.sv
rtl/cll_out_if.sv
rtl/cll_ctrl.sv
rtl/cll_dpath.sv
rtl/cursor_linked_list_engine.sv
tb/tb_cursor_linked_list_engine.sv
